// File: hw/rtl/sat_pkg.sv
package sat_pkg;

    localparam int TIME_W   = 12;
    localparam int DAYS_W   = 7;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 4;

    localparam logic [TIME_W-1:0] MAX_TIME = 12'd2359;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd4;

    typedef struct packed {
        logic [TIME_W-1:0] hhmm;
        logic [DAYS_W-1:0] days;
    } t_entry;

endpackage

// File: hw/rtl/sorted_alarm_table_top.sv
// Time-ordered alarm table held in one synchronous RAM of DEPTH entries. A command is
// taken when start is high and busy is low. Clear, a read of an empty table, an insert
// into an empty table, and any insert or delete that is rejected (invalid time, full
// table, empty table), answer with one beat in the next cycle. An accepted insert walks
// the table from the tail, moving one entry per cycle; a delete scans from the head for
// the key and then closes the gap one entry per cycle; a read gives one beat per stored
// entry. The single RAM port pair (one read, one write per cycle) sets these rates.
// Result beats last exactly one cycle and are not held back: the receiver must take
// every beat o_strobe marks.
module sorted_alarm_table_top #(
    parameter int DEPTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [sat_pkg::CMD_W-1:0]       i_cmd,
    input  logic [sat_pkg::TIME_W-1:0]      i_hhmm,
    input  logic [sat_pkg::DAYS_W-1:0]      i_day_mask,
    output logic                            o_strobe,
    output logic [sat_pkg::STATUS_W-1:0]    o_status,
    output logic [sat_pkg::INDEX_W-1:0]     o_entry_index,
    output logic [sat_pkg::TIME_W-1:0]      o_entry_time,
    output logic [sat_pkg::DAYS_W-1:0]      o_entry_days,
    output logic                            o_last
);
    import sat_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_INS    = 3'd1;
    localparam logic [2:0] S_PUT    = 3'd2;
    localparam logic [2:0] S_DFIND  = 3'd3;
    localparam logic [2:0] S_DSHIFT = 3'd4;
    localparam logic [2:0] S_RD     = 3'd5;

    t_entry mem [DEPTH];
    t_entry r_rdata;

    logic [2:0]          r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_ptr, n_ptr;
    logic [TIME_W-1:0]   r_time, n_time;
    logic [DAYS_W-1:0]   r_days, n_days;
    logic                r_strobe, n_strobe;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [INDEX_W-1:0]  r_index, n_index;
    logic [TIME_W-1:0]   r_etime, n_etime;
    logic [DAYS_W-1:0]   r_edays, n_edays;
    logic                r_last, n_last;

    logic                we;
    logic [AW-1:0]       waddr;
    t_entry              wdata;
    logic [AW-1:0]       raddr;
    logic                accept;
    logic                shift;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign shift  = (r_ptr == '0) ? (r_time < r_rdata.hhmm)
                                  : (r_rdata.hhmm >= r_time);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_time   = r_time;
        n_days   = r_days;
        n_strobe = 1'b0;
        n_status = ST_OK;
        n_index  = '0;
        n_etime  = '0;
        n_edays  = '0;
        n_last   = 1'b0;
        we       = 1'b0;
        waddr    = '0;
        wdata    = t_entry'{hhmm: r_time, days: r_days};
        raddr    = AW'(r_ptr);
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_time   = i_hhmm;
                    n_days   = i_day_mask;
                    n_strobe = 1'b1;
                    n_last   = 1'b1;
                    unique case (i_cmd)
                        CMD_INSERT: begin
                            if (i_hhmm > MAX_TIME) begin
                                n_status = ST_INVALID;
                            end else if (r_count == CW'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else if (r_count == '0) begin
                                we      = 1'b1;
                                wdata   = t_entry'{hhmm: i_hhmm, days: i_day_mask};
                                n_count = CW'(1);
                            end else begin
                                n_strobe = 1'b0;
                                n_last   = 1'b0;
                                n_ptr    = r_count - 1'b1;
                                raddr    = AW'(r_count - 1'b1);
                                n_state  = S_INS;
                            end
                        end
                        CMD_DELETE: begin
                            if (i_hhmm > MAX_TIME) begin
                                n_status = ST_INVALID;
                            end else if (r_count == '0) begin
                                n_status = ST_NOT_FOUND;
                            end else begin
                                n_strobe = 1'b0;
                                n_last   = 1'b0;
                                n_ptr    = '0;
                                raddr    = '0;
                                n_state  = S_DFIND;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        CMD_READ: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_strobe = 1'b0;
                                n_last   = 1'b0;
                                n_ptr    = '0;
                                raddr    = '0;
                                n_state  = S_RD;
                            end
                        end
                    endcase
                end
            end
            S_INS: begin
                we    = 1'b1;
                waddr = AW'(r_ptr + 1'b1);
                if (shift) begin
                    wdata = r_rdata;
                    if (r_ptr == '0) begin
                        n_state = S_PUT;
                    end else begin
                        n_ptr = r_ptr - 1'b1;
                        raddr = AW'(r_ptr - 1'b1);
                    end
                end else begin
                    n_count  = r_count + 1'b1;
                    n_strobe = 1'b1;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_PUT: begin
                we       = 1'b1;
                n_count  = r_count + 1'b1;
                n_strobe = 1'b1;
                n_last   = 1'b1;
                n_state  = S_IDLE;
            end
            S_DFIND: begin
                raddr = AW'(r_ptr + 1'b1);
                if (r_rdata.hhmm == r_time) begin
                    n_ptr   = r_ptr + 1'b1;
                    n_state = S_DSHIFT;
                end else if (r_ptr == r_count - 1'b1) begin
                    n_status = ST_NOT_FOUND;
                    n_strobe = 1'b1;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_DSHIFT: begin
                if (r_ptr == r_count) begin
                    n_count  = r_count - 1'b1;
                    n_strobe = 1'b1;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    we    = 1'b1;
                    waddr = AW'(r_ptr - 1'b1);
                    wdata = r_rdata;
                    raddr = AW'(r_ptr + 1'b1);
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_RD: begin
                n_strobe = 1'b1;
                n_index  = INDEX_W'(r_ptr);
                n_etime  = r_rdata.hhmm;
                n_edays  = r_rdata.days;
                raddr    = AW'(r_ptr + 1'b1);
                if (r_ptr == r_count - 1'b1) begin
                    n_last  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_time   <= n_time;
        r_days   <= n_days;
        r_status <= n_status;
        r_index  <= n_index;
        r_etime  <= n_etime;
        r_edays  <= n_edays;
        r_last   <= n_last;
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_entry_index = r_index;
    assign o_entry_time  = r_etime;
    assign o_entry_days  = r_edays;
    assign o_last        = r_last;

endmodule

// File: hw/rtl/sat_checker.sv
module sat_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input logic [sat_pkg::CMD_W-1:0]       i_cmd,
    input logic [sat_pkg::TIME_W-1:0]      i_hhmm,
    input logic                            o_strobe,
    input logic [sat_pkg::STATUS_W-1:0]    o_status,
    input logic [sat_pkg::INDEX_W-1:0]     o_entry_index,
    input logic [sat_pkg::TIME_W-1:0]      o_entry_time,
    input logic [sat_pkg::DAYS_W-1:0]      o_entry_days,
    input logic                            o_last
);
    import sat_pkg::*;

    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_OK) |-> o_last)
        else $error("error status not on a final beat");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> !busy)
        else $error("still busy on final beat");

    a_invalid_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd == CMD_INSERT || i_cmd == CMD_DELETE)
         && i_hhmm > MAX_TIME)
        |=> (o_strobe && o_last && o_status == ST_INVALID))
        else $error("invalid time not flagged");

    a_clear_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd == CMD_CLEAR)
        |=> (o_strobe && o_last && o_status == ST_OK))
        else $error("clear not acknowledged");

    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_OK)
        |-> (o_entry_index == '0 && o_entry_time == '0 && o_entry_days == '0))
        else $error("entry fields set on a status beat");

endmodule

bind sorted_alarm_table_top sat_checker u_sat_checker (.*);
